FILE: hw/rtl/three_out_of_six_codec_macros.svh
// ----------------------------------------------------------------------------
// three_out_of_six_codec_macros.svh
// Assertion macros shared by the codec RTL; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef THREE_OUT_OF_SIX_CODEC_MACROS_SVH
`define THREE_OUT_OF_SIX_CODEC_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked at every rising edge out of reset
`define TSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsc assertion failed");
// next-cycle implication
`define TSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsc assertion failed");
`else
`define TSC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TSC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, constants and code-table functions of the 3-of-6 codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsc_pkg;

  // job queue between front and back
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  // three coded bytes per group
  localparam int ChipW  = 24;

  // nibble to 6-chip code table
  localparam logic [5:0] ChipCode [16] = '{
    6'h16, 6'h0D, 6'h0E, 6'h0B, 6'h1C, 6'h19, 6'h1A, 6'h13,
    6'h2C, 6'h25, 6'h26, 6'h23, 6'h34, 6'h31, 6'h32, 6'h29
  };

  typedef enum logic [1:0] {
    JK_ENC,   // three coded bytes
    JK_DEC,   // two plain bytes
    JK_END,   // bare end marker
    JK_ERR    // code error marker
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [ChipW-1:0]   data;
    logic               last;
  } job_t;

  function automatic logic [5:0] chip_of(input logic [3:0] nib);
    return ChipCode[nib];
  endfunction

  // returns {bad, nibble}; bad set when the code is not in the table
  function automatic logic [4:0] nibble_of(input logic [5:0] code);
    logic [4:0] res;
    res = 5'h10;
    for (int k = 0; k < 16; k++) begin
      if (ChipCode[k] == code) res = {1'b0, 4'(k)};
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/tsc_if.sv
// ----------------------------------------------------------------------------
// tsc_if
// Valid/ready channel interfaces for codec input and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface tsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic       code_error;

  modport source (output valid, out_byte, out_valid, out_last, code_error, input ready);
  modport sink   (input valid, out_byte, out_valid, out_last, code_error, output ready);
endinterface

FILE: hw/rtl/tsc_queue.sv
// ----------------------------------------------------------------------------
// tsc_queue
// Two-entry job queue decoupling the front classifier from the result back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tsc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output tsc_pkg::job_t head_job
);
  import tsc_pkg::*;

  job_t             mem [QDepth];
  logic [QAw-1:0]   wr_ptr;
  logic [QAw-1:0]   rd_ptr;
  logic [QCw-1:0]   count;

  assign full     = (count == QCw'(QDepth));
  assign q_valid  = (count != '0);
  assign head_job = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QAw'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QAw'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

endmodule

FILE: hw/rtl/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// Accepts input bytes, gathers groups, maps codes and queues at most one job per group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  tsc_in_if.sink        din,
  input  logic          q_full,
  output logic          push,
  output tsc_pkg::job_t push_job
);
  import tsc_pkg::*;

  logic        direction;
  logic [15:0] held_bytes;
  logic [1:0]  group_position;
  logic        discarding;

  logic [15:0] held_bytes_next;
  logic [1:0]  group_position_next;
  logic        discarding_next;
  logic        has_job;
  job_t        job;

  logic        accept;
  logic [7:0]  b0, b1;
  logic [23:0] chips;
  logic [4:0]  n0, n1, n2, n3;

  assign din.ready = !q_full;
  assign accept    = din.valid && din.ready;
  assign push      = accept && has_job;
  assign push_job  = job;

  // encode pairing
  assign b0 = (group_position == 2'd0) ? din.data_byte : held_bytes[7:0];
  assign b1 = (group_position == 2'd0) ? 8'h00 : din.data_byte;

  // decode lookups on the completed group
  assign chips = {held_bytes, din.data_byte};
  assign n0 = nibble_of(chips[23:18]);
  assign n1 = nibble_of(chips[17:12]);
  assign n2 = nibble_of(chips[11:6]);
  assign n3 = nibble_of(chips[5:0]);

  // classify the item and work out the group state
  always_comb begin
    held_bytes_next     = held_bytes;
    group_position_next = group_position;
    discarding_next     = discarding;
    has_job             = 1'b0;
    job.kind            = JK_ENC;
    job.data            = '0;
    job.last            = din.last_byte;
    if (!direction) begin
      if (group_position == 2'd0 && !din.last_byte) begin
        held_bytes_next     = {8'h00, din.data_byte};
        group_position_next = 2'd1;
      end else begin
        has_job             = 1'b1;
        job.kind            = JK_ENC;
        job.data            = {chip_of(b0[7:4]), chip_of(b0[3:0]),
                               chip_of(b1[7:4]), chip_of(b1[3:0])};
        held_bytes_next     = '0;
        group_position_next = 2'd0;
      end
    end else if (discarding) begin
      if (din.last_byte) begin
        held_bytes_next     = '0;
        group_position_next = 2'd0;
        discarding_next     = 1'b0;
      end
    end else if (group_position < 2'd2) begin
      if (din.last_byte) begin
        // partial group at frame end: drop it, mark the end
        held_bytes_next     = '0;
        group_position_next = 2'd0;
        has_job             = 1'b1;
        job.kind            = JK_END;
      end else begin
        held_bytes_next     = {held_bytes[7:0], din.data_byte};
        group_position_next = group_position + 2'd1;
      end
    end else begin
      held_bytes_next     = '0;
      group_position_next = 2'd0;
      has_job             = 1'b1;
      if (n0[4] || n1[4] || n2[4] || n3[4]) begin
        job.kind        = JK_ERR;
        discarding_next = !din.last_byte;
      end else begin
        job.kind = JK_DEC;
        job.data = {8'h00, n0[3:0], n1[3:0], n2[3:0], n3[3:0]};
      end
    end
  end

  // direction register and group state
  always_ff @(posedge clk) begin
    if (rst) begin
      direction      <= 1'b0;
      held_bytes     <= '0;
      group_position <= '0;
      discarding     <= 1'b0;
    end else if (cfg_we) begin
      direction      <= cfg_wdata;
      held_bytes     <= '0;
      group_position <= '0;
      discarding     <= 1'b0;
    end else if (accept) begin
      held_bytes     <= held_bytes_next;
      group_position <= group_position_next;
      discarding     <= discarding_next;
    end
  end

endmodule

FILE: hw/rtl/tsc_back.sv
// ----------------------------------------------------------------------------
// tsc_back
// Takes jobs from the queue and emits their result items one per cycle while the output is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tsc_pkg::job_t head_job,
  output logic          pop,
  tsc_out_if.source     dout
);
  import tsc_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] step;

  logic       ovalid;
  logic [7:0] obyte;
  logic       ovld, olast, oerr;

  logic [1:0] final_step;
  logic [7:0] r_byte;
  logic       r_valid, r_last, r_err;
  logic       slot, fin;

  // result of the current step
  always_comb begin
    final_step = 2'd0;
    r_byte     = 8'h00;
    r_valid    = 1'b0;
    r_last     = 1'b1;
    r_err      = 1'b0;
    unique case (cur.kind)
      JK_ENC: begin
        final_step = 2'd2;
        r_valid    = 1'b1;
        r_last     = cur.last && (step == 2'd2);
        case (step)
          2'd0:    r_byte = cur.data[23:16];
          2'd1:    r_byte = cur.data[15:8];
          default: r_byte = cur.data[7:0];
        endcase
      end
      JK_DEC: begin
        final_step = 2'd1;
        r_valid    = 1'b1;
        r_last     = cur.last && (step == 2'd1);
        r_byte     = (step == 2'd0) ? cur.data[15:8] : cur.data[7:0];
      end
      JK_END: begin
        r_err = 1'b0;
      end
      JK_ERR: begin
        r_err = 1'b1;
      end
      default: begin
        r_err = 1'b0;
      end
    endcase
  end

  assign slot = !ovalid || dout.ready;
  assign fin  = busy && slot && (step == final_step);
  assign pop  = q_valid && (!busy || fin);

  // job sequencing and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      step   <= '0;
      ovalid <= 1'b0;
    end else begin
      if (slot) ovalid <= busy;
      if (pop) begin
        busy <= 1'b1;
        step <= '0;
      end else if (fin) begin
        busy <= 1'b0;
      end else if (busy && slot) begin
        step <= step + 2'd1;
      end
    end
  end

  // job and output payload
  always_ff @(posedge clk) begin
    if (pop) cur <= head_job;
    if (slot && busy) begin
      obyte <= r_byte;
      ovld  <= r_valid;
      olast <= r_last;
      oerr  <= r_err;
    end
  end

  assign dout.valid      = ovalid;
  assign dout.out_byte   = obyte;
  assign dout.out_valid  = ovld;
  assign dout.out_last   = olast;
  assign dout.code_error = oerr;

endmodule

FILE: hw/rtl/three_out_of_six_codec.sv
// ----------------------------------------------------------------------------
// three_out_of_six_codec
// Byte-stream 3-out-of-6 line codec. cfg_wdata selects the mode (0 encode,
// 1 decode) and a write drops any partial frame. Encode turns two bytes into
// three coded bytes (an odd last byte pairs with zero); decode turns three
// coded bytes into two bytes, ends a frame with a bare end marker on a
// trailing partial group and with one error item on a bad code, then skips
// the rest of that frame. Input items are taken one per cycle while the
// two-entry job queue has room; the back end emits one result item per
// cycle while the output is ready, so encode, not decode, is bound by it.
// Results pass through the job queue, job register and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_out_of_six_codec_macros.svh"

module three_out_of_six_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  tsc_in_if.sink     din,
  tsc_out_if.source  dout
);
  import tsc_pkg::*;

  logic q_full, q_valid, push, pop;
  job_t push_job, head_job;
  logic err_shape;

  // classify input items into jobs
  tsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .din      (din),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  tsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .head_job(head_job)
  );

  // emit result items
  tsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head_job(head_job),
    .pop     (pop),
    .dout    (dout)
  );

  // an error item is a bare marker that ends the frame
  assign err_shape = !dout.out_valid && dout.out_last && (dout.out_byte == 8'h00);

  // checks
  `TSC_ASSERT_IMP(a_no_push_full, clk, rst, push, !q_full)
  `TSC_ASSERT_IMP(a_pop_has_job, clk, rst, pop, q_valid)
  `TSC_ASSERT_IMP(a_err_marker, clk, rst, dout.valid && dout.code_error, err_shape)
  `TSC_ASSERT_NXT(a_out_hold, clk, rst, dout.valid && !dout.ready, dout.valid && $stable(dout.out_byte))

endmodule

FILE: bench/tb_three_out_of_six_codec.sv
// ----------------------------------------------------------------------------
// tb_three_out_of_six_codec
// Self-checking bench for the 3-out-of-6 byte codec. A queue-fed driver and
// a clocked monitor exercise encode and decode frames (good groups, odd
// tails, partial groups, bad codes, discarded frame tails) under random
// idling on both channels. Each result item is checked against a local
// prediction of the code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_three_out_of_six_codec;

  // direction register codes
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 8;
  localparam int IdlePct      = 7;
  localparam int PhaseItems   = 18;
  localparam int NumPhases    = 7;

  // nibble to 6-chip code
  localparam logic [5:0] ChipTab [16] = '{
    6'h16, 6'h0D, 6'h0E, 6'h0B, 6'h1C, 6'h19, 6'h1A, 6'h13,
    6'h2C, 6'h25, 6'h26, 6'h23, 6'h34, 6'h31, 6'h32, 6'h29
  };

  localparam logic PhaseDir [NumPhases] = '{
    DirDecode, DirEncode, DirEncode, DirDecode, DirDecode, DirEncode, DirDecode
  };

  typedef struct packed {
    logic [7:0] octet;
    logic       lst;
  } in_item_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       vld;
    logic       lst;
    logic       err;
  } result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic calm;
  logic in_taken;

  tsc_in_if  din_if ();
  tsc_out_if dout_if ();

  three_out_of_six_codec u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .din       (din_if),
    .dout      (dout_if)
  );

  in_item_t pending_items [$];
  result_t  owed_results [$];

  // predicted codec state
  logic        model_dir;
  logic [15:0] held;
  logic [1:0]  grp_pos;
  logic        skipping;

  int n_mismatch;
  int n_accepted;
  int n_results;
  int n_err_results;
  int n_end_markers;
  int n_writes;
  int cycles;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic logic [23:0] encode_pair(input logic [7:0] b0, input logic [7:0] b1);
    return {ChipTab[b0[7:4]], ChipTab[b0[3:0]], ChipTab[b1[7:4]], ChipTab[b1[3:0]]};
  endfunction

  // bit 4 set when the code is outside the table
  function automatic logic [4:0] chip_to_nibble(input logic [5:0] code);
    logic [4:0] nib;
    nib = 5'h10;
    for (int k = 0; k < 16; k++) begin
      if (ChipTab[k] == code) nib = 5'(k);
    end
    return nib;
  endfunction

  function automatic result_t make_result(input logic [7:0] octet, input logic vld,
                                          input logic lst, input logic err);
    result_t r;
    r.octet = octet;
    r.vld   = vld;
    r.lst   = lst;
    r.err   = err;
    return r;
  endfunction

  task automatic clear_group_state();
    held     = '0;
    grp_pos  = '0;
    skipping = 1'b0;
  endtask

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_mismatch++;
  endtask

  task automatic queue_item(input logic [7:0] octet, input logic lst);
    in_item_t it;
    it.octet = octet;
    it.lst   = lst;
    pending_items.push_back(it);
  endtask

  task automatic write_direction(input logic d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_writes++;
  endtask

  // all items sent, all results in, then a settling wait
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || din_if.valid || owed_results.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Prediction: one accepted item in, zero to three results queued
  // ---------------------------------------------------------------------------
  task automatic step_line_code(input in_item_t it);
    logic [23:0] chips;
    logic [4:0]  n0, n1, n2, n3;
    if (model_dir == DirEncode) begin
      if (grp_pos == 2'd0 && !it.lst) begin
        held    = {8'h00, it.octet};
        grp_pos = 2'd1;
      end else begin
        // odd final byte pairs with zero
        chips = (grp_pos == 2'd0) ? encode_pair(it.octet, 8'h00)
                                  : encode_pair(held[7:0], it.octet);
        owed_results.push_back(make_result(chips[23:16], 1'b1, 1'b0, 1'b0));
        owed_results.push_back(make_result(chips[15:8], 1'b1, 1'b0, 1'b0));
        owed_results.push_back(make_result(chips[7:0], 1'b1, it.lst, 1'b0));
        held    = '0;
        grp_pos = '0;
      end
    end else if (skipping) begin
      // rest of a bad frame
      if (it.lst) clear_group_state();
    end else if (grp_pos < 2'd2) begin
      if (it.lst) begin
        // trailing partial group: bare end marker
        clear_group_state();
        owed_results.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b0));
      end else begin
        held    = {held[7:0], it.octet};
        grp_pos = grp_pos + 2'd1;
      end
    end else begin
      chips   = {held, it.octet};
      held    = '0;
      grp_pos = '0;
      n0 = chip_to_nibble(chips[23:18]);
      n1 = chip_to_nibble(chips[17:12]);
      n2 = chip_to_nibble(chips[11:6]);
      n3 = chip_to_nibble(chips[5:0]);
      if (n0[4] | n1[4] | n2[4] | n3[4]) begin
        skipping = !it.lst;
        owed_results.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1));
      end else begin
        owed_results.push_back(make_result({n0[3:0], n1[3:0]}, 1'b1, 1'b0, 1'b0));
        owed_results.push_back(make_result({n2[3:0], n3[3:0]}, 1'b1, it.lst, 1'b0));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("run exceeded %0d cycles", CycleLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: input items from the pending queue, random ready on results
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    in_item_t it;
    if (rst) begin
      din_if.valid <= 1'b0;
    end else if (!din_if.valid || in_taken) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        it = pending_items.pop_front();
        din_if.valid     <= 1'b1;
        din_if.data_byte <= it.octet;
        din_if.last_byte <= it.lst;
      end else begin
        din_if.valid <= 1'b0;
      end
    end
    dout_if.ready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted items, check accepted results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_item_t it;
    result_t  got, want;
    if (rst) begin
      in_taken  <= 1'b0;
      model_dir = DirEncode;
      clear_group_state();
    end else begin
      in_taken <= din_if.valid && din_if.ready;
      if (cfg_we) begin
        model_dir = cfg_wdata;
        clear_group_state();
      end
      if (din_if.valid && din_if.ready) begin
        it.octet = din_if.data_byte;
        it.lst   = din_if.last_byte;
        n_accepted++;
        step_line_code(it);
      end
      if (dout_if.valid && dout_if.ready) begin
        got = make_result(dout_if.out_byte, dout_if.out_valid, dout_if.out_last,
                          dout_if.code_error);
        n_results++;
        if (got.err) n_err_results++;
        if (!got.vld && !got.err) n_end_markers++;
        if (owed_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result byte %h valid %b last %b err %b",
                                  got.octet, got.vld, got.lst, got.err));
        end else begin
          want = owed_results.pop_front();
          if (got.octet !== want.octet)
            flag_mismatch($sformatf("out_byte %h, want %h", got.octet, want.octet));
          if (got.vld !== want.vld)
            flag_mismatch($sformatf("out_valid %b, want %b", got.vld, want.vld));
          if (got.lst !== want.lst)
            flag_mismatch($sformatf("out_last %b, want %b", got.lst, want.lst));
          if (got.err !== want.err)
            flag_mismatch($sformatf("code_error %b, want %b", got.err, want.err));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          n, nbytes, ngroups, bad_at, tail, kind;
    logic [23:0] chips;
    logic [7:0]  b;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    calm              = 1'b0;
    din_if.valid      = 1'b0;
    din_if.data_byte  = 8'h00;
    din_if.last_byte  = 1'b0;
    dout_if.ready     = 1'b0;
    n_mismatch        = 0;
    n_accepted        = 0;
    n_results         = 0;
    n_err_results     = 0;
    n_end_markers     = 0;
    n_writes          = 0;
    cycles            = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed encode: extremes, every nibble value in one half or the other, odd tail
    write_direction(DirEncode);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h10, 1'b0);
    queue_item(8'h32, 1'b0);
    queue_item(8'h54, 1'b0);
    queue_item(8'h76, 1'b0);
    queue_item(8'h98, 1'b0);
    queue_item(8'hBA, 1'b0);
    queue_item(8'hDC, 1'b0);
    queue_item(8'hFE, 1'b0);
    queue_item(8'h00, 1'b1);
    queue_item(8'h5A, 1'b1);
    // held byte left behind, dropped by the next write
    queue_item(8'h81, 1'b0);
    wait_drained();

    // directed decode
    write_direction(DirDecode);
    chips = encode_pair(8'h00, 8'hFF);
    for (int k = 0; k < 3; k++) queue_item(chips[23 - 8*k -: 8], k == 2);
    // partial groups of one and two bytes
    chips = encode_pair(8'hA5, 8'h3C);
    queue_item(chips[23:16], 1'b1);
    queue_item(chips[23:16], 1'b0);
    queue_item(chips[15:8], 1'b1);
    // bad code mid-frame, then the tail is skipped
    queue_item(8'hFF, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b1);
    // bad code on the final group
    queue_item(8'h00, 1'b0);
    queue_item(8'h00, 1'b0);
    queue_item(8'h00, 1'b1);
    wait_drained();

    // random phases, one of them with no idling
    for (int p = 0; p < NumPhases; p++) begin
      write_direction(PhaseDir[p]);
      calm = (p == 3);
      n = 0;
      while (n < PhaseItems) begin
        kind = $urandom_range(99);
        if (PhaseDir[p] == DirEncode) begin
          nbytes = $urandom_range(1, 9);
          for (int k = 0; k < nbytes; k++) queue_item(8'($urandom_range(255)), k == nbytes - 1);
        end else if (kind < 10) begin
          // noise frame
          nbytes = $urandom_range(1, 7);
          for (int k = 0; k < nbytes; k++) queue_item(8'($urandom_range(255)), k == nbytes - 1);
        end else begin
          // coded frame, sometimes with a corrupted byte or a partial tail
          ngroups = $urandom_range(1, 3);
          bad_at  = (kind < 30) ? $urandom_range(0, 3*ngroups - 1) : -1;
          tail    = (kind >= 85) ? $urandom_range(1, 2) : 0;
          nbytes  = 3*ngroups + tail;
          for (int k = 0; k < nbytes; k++) begin
            if (k % 3 == 0)
              chips = encode_pair(8'($urandom_range(255)), 8'($urandom_range(255)));
            if (k >= 3*ngroups || k == bad_at) b = 8'($urandom_range(255));
            else b = chips[23 - 8*(k % 3) -: 8];
            queue_item(b, k == nbytes - 1);
          end
        end
        n += nbytes;
      end
      wait_drained();
    end
    calm = 1'b0;

    // final drain with its own bound
    for (int k = 0; k < 2000 && (owed_results.size() != 0 || din_if.valid); k++)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (owed_results.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", owed_results.size()));

    $display("covered %0d input items and %0d result items (%0d code errors, %0d end markers)",
             n_accepted, n_results, n_err_results, n_end_markers);
    $display("direction written %0d times over encode and decode phases, %0d mismatches",
             n_writes, n_mismatch);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_if.sv
hw/rtl/tsc_queue.sv
hw/rtl/tsc_front.sv
hw/rtl/tsc_back.sv
hw/rtl/three_out_of_six_codec.sv
bench/tb_three_out_of_six_codec.sv
